@@ design/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the controller block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset
`define PCA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on every clock edge out of reset
`define PCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCA_ASSERT_IMPL(label, ante, cons)
`define PCA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/pca_pkg.sv @@
// Shared types, command codes and constants of the PID controller block
package pca_pkg;

    localparam int CmdW   = 5;
    localparam int DivW   = 44;
    localparam int DvsW   = 32;
    localparam int ProdW  = 56;
    localparam int IdxW   = 8;

    typedef logic [CmdW-1:0] t_cmd;

    localparam t_cmd C_NOP    = 5'd0;
    localparam t_cmd C_LOAD   = 5'd1;
    localparam t_cmd C_CLEAR  = 5'd2;
    localparam t_cmd C_ZERO   = 5'd3;
    localparam t_cmd C_MUL_P  = 5'd4;
    localparam t_cmd C_MUL_ED = 5'd5;
    localparam t_cmd C_INTEG  = 5'd6;
    localparam t_cmd C_MUL_B  = 5'd7;
    localparam t_cmd C_DIV_B  = 5'd8;
    localparam t_cmd C_CLAMP  = 5'd9;
    localparam t_cmd C_MUL_I  = 5'd10;
    localparam t_cmd C_DIV_I  = 5'd11;
    localparam t_cmd C_GET_I  = 5'd12;
    localparam t_cmd C_MUL_D1 = 5'd13;
    localparam t_cmd C_MUL_D2 = 5'd14;
    localparam t_cmd C_DIV_D  = 5'd15;
    localparam t_cmd C_SUM    = 5'd16;
    localparam t_cmd C_PUSH   = 5'd17;

    typedef struct packed {
        logic op_clear;
        logic dt_zero;
        logic gain_i_zero;
        logic div_done;
        logic out_free;
    } t_stat;

    localparam logic [IdxW-1:0] REG_GAIN_P = 8'd0;
    localparam logic [IdxW-1:0] REG_GAIN_I = 8'd1;
    localparam logic [IdxW-1:0] REG_GAIN_D = 8'd2;
    localparam logic [IdxW-1:0] REG_LIMIT  = 8'd3;

    localparam logic [14:0] LIMIT_RESET = 15'd10240;
    localparam logic [20:0] MS_SCALE    = 21'd256000;
    localparam logic [20:0] MS_PER_S    = 21'd1000;
    // ceil(2^37 / 125): exact floor(y / 125) for any 30 bit y
    localparam logic [30:0] RECIP_125   = 31'd1099511628;
    localparam logic signed [49:0] INTEG_MAX = 50'sd549755813887;
    localparam logic signed [49:0] INTEG_MIN = -50'sd549755813888;

endpackage

@@ design/pid_controller_anti_windup_unit.sv @@
// Top level of the fixed-point PID controller with conditional-integration anti-windup
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one request: op, target, measured
//   and time_ms. op clear zeroes the stored error and integral and takes the time.
//   Output channel (o_out_valid/i_out_ready) returns one drive value per request.
//   Configuration channel (i_cfg_valid/o_cfg_ready, always ready) writes gain_p,
//   gain_i, gain_d and output_limit by index 0..3; other indexes are dropped.
//   Write configuration only while no request is in flight.
// Sequencing:
//   A clear or zero-elapsed-time request goes straight to the output push; a
//   control step also runs the radix-2 divider: for the limit/ki bound and for
//   the derivative when ki is nonzero, or for the derivative alone when ki is
//   zero.
//   The input reopens the cycle after the result is pushed, so one request is
//   worked at a time.
// Reset: synchronous, active low; clears gains, sets the limit to 40.0 and zeroes
//   the stored error, integral and timestamp.
// Stall: the result sits in an output register; the next request is accepted and
//   worked meanwhile, and its result holds until the output register frees up.
`include "assert_macros.svh"
module pid_controller_anti_windup_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic signed [15:0]        i_target,
    input  logic signed [15:0]        i_measured,
    input  logic [31:0]               i_time_ms,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [15:0]        o_drive,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pca_pkg::IdxW-1:0]  i_cfg_index,
    input  logic [15:0]               i_cfg_data
);
    pca_pkg::t_cmd  w_cmd;
    pca_pkg::t_stat w_stat;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // Sequencer: one step of the update per state
    pca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, stored controller state and output register
    pca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_target    (i_target),
        .i_measured  (i_measured),
        .i_time_ms   (i_time_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive)
    );

    // An accepted request keeps the input closed on the next cycle
    `PCA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // Divider finishes only while a request is in flight
    `PCA_ASSERT_IMPL(a_div_in_flight, w_stat.div_done, !o_in_ready)
    // A push into the output register never happens while the input is open
    `PCA_ASSERT_IMPL(a_push_in_flight, w_cmd == pca_pkg::C_PUSH, !o_in_ready)
endmodule

@@ design/pca_div.sv @@
// Restoring divider, one quotient bit per cycle
module pca_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pca_pkg::DivW-1:0]    i_dividend,
    input  logic [pca_pkg::DvsW-1:0]    i_divisor,
    output logic                        o_done,
    output logic [pca_pkg::DivW-1:0]    o_quotient
);
    logic [pca_pkg::DivW-1:0] r_quo;
    logic [pca_pkg::DvsW-1:0] r_rem;
    logic [pca_pkg::DvsW-1:0] r_dvs;
    logic [5:0]               r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [pca_pkg::DvsW:0]   w_sh;
    logic [pca_pkg::DvsW+1:0] w_diff;

    assign w_sh   = {r_rem, r_quo[pca_pkg::DivW-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(pca_pkg::DivW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!w_diff[pca_pkg::DvsW+1]) begin
                    r_rem <= w_diff[pca_pkg::DvsW-1:0];
                end else begin
                    r_rem <= w_sh[pca_pkg::DvsW-1:0];
                end
                r_quo <= {r_quo[pca_pkg::DivW-2:0], ~w_diff[pca_pkg::DvsW+1]};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ design/pca_ctrl.sv @@
// Sequencer that steps the datapath through one control update
module pca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pca_pkg::t_stat     i_stat,
    output logic               o_in_ready,
    output pca_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_MED    = 4'd2;
    localparam logic [3:0] S_INTEG  = 4'd3;
    localparam logic [3:0] S_MB     = 4'd4;
    localparam logic [3:0] S_DB     = 4'd5;
    localparam logic [3:0] S_DBW    = 4'd6;
    localparam logic [3:0] S_MI     = 4'd7;
    localparam logic [3:0] S_DI     = 4'd8;
    localparam logic [3:0] S_DIW    = 4'd9;
    localparam logic [3:0] S_MD1    = 4'd10;
    localparam logic [3:0] S_MD2    = 4'd11;
    localparam logic [3:0] S_DD     = 4'd12;
    localparam logic [3:0] S_DDW    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = pca_pkg::C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = pca_pkg::C_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op_clear) begin
                    o_cmd   = pca_pkg::C_CLEAR;
                    n_state = S_OUT;
                end else if (i_stat.dt_zero) begin
                    o_cmd   = pca_pkg::C_ZERO;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = pca_pkg::C_MUL_P;
                    n_state = S_MED;
                end
            end
            S_MED: begin
                o_cmd   = pca_pkg::C_MUL_ED;
                n_state = S_INTEG;
            end
            S_INTEG: begin
                o_cmd   = pca_pkg::C_INTEG;
                n_state = i_stat.gain_i_zero ? S_MD1 : S_MB;
            end
            S_MB: begin
                o_cmd   = pca_pkg::C_MUL_B;
                n_state = S_DB;
            end
            S_DB: begin
                o_cmd   = pca_pkg::C_DIV_B;
                n_state = S_DBW;
            end
            S_DBW: begin
                if (i_stat.div_done) begin
                    o_cmd   = pca_pkg::C_CLAMP;
                    n_state = S_MI;
                end
            end
            S_MI: begin
                o_cmd   = pca_pkg::C_MUL_I;
                n_state = S_DI;
            end
            S_DI: begin
                o_cmd   = pca_pkg::C_DIV_I;
                n_state = S_DIW;
            end
            S_DIW: begin
                o_cmd   = pca_pkg::C_GET_I;
                n_state = S_MD1;
            end
            S_MD1: begin
                o_cmd   = pca_pkg::C_MUL_D1;
                n_state = S_MD2;
            end
            S_MD2: begin
                o_cmd   = pca_pkg::C_MUL_D2;
                n_state = S_DD;
            end
            S_DD: begin
                o_cmd   = pca_pkg::C_DIV_D;
                n_state = S_DDW;
            end
            S_DDW: begin
                if (i_stat.div_done) begin
                    o_cmd   = pca_pkg::C_SUM;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd   = pca_pkg::C_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

@@ design/pca_dp.sv @@
// Datapath: configuration, controller state, shared multiplier and divider
module pca_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pca_pkg::t_cmd              i_cmd,
    output pca_pkg::t_stat             o_stat,
    input  logic                       i_cfg_valid,
    input  logic [pca_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_op,
    input  logic signed [15:0]         i_target,
    input  logic signed [15:0]         i_measured,
    input  logic [31:0]                i_time_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [15:0]         o_drive
);
    logic [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [14:0] r_limit;

    logic signed [16:0] r_last_err;
    logic signed [39:0] r_ei;
    logic [31:0]        r_last_time;

    logic               r_op;
    logic signed [16:0] r_err;
    logic [31:0]        r_now;
    logic [31:0]        r_dt;
    logic signed [33:0] r_p;
    logic signed [24:0] r_iterm;
    logic [23:0]        r_iq;
    logic               r_i_neg;
    logic               r_d_neg;
    logic signed [pca_pkg::ProdW-1:0] r_prod;
    logic signed [15:0] r_res;
    logic signed [15:0] r_out_drive;
    logic               r_out_valid;

    logic signed [34:0] w_ma;
    logic signed [20:0] w_mb;
    logic signed [pca_pkg::ProdW-1:0] w_prod;
    logic [39:0]        w_abs_ei;
    logic signed [17:0] w_diff;
    logic [pca_pkg::ProdW-1:0] w_abs_prod;
    logic [60:0]        w_recip;
    logic               w_div_start;
    logic [pca_pkg::DivW-1:0]  w_dividend;
    logic [pca_pkg::DvsW-1:0]  w_divisor;
    logic               w_div_done;
    logic [pca_pkg::DivW-1:0]  w_quo;
    logic signed [34:0] w_lim;
    logic               w_integ;
    logic signed [49:0] w_acc;
    logic signed [40:0] w_bound;
    logic signed [45:0] w_dterm;
    logic signed [45:0] w_sum;
    logic signed [23:0] w_clip;
    logic signed [23:0] w_adj;

    assign w_abs_ei   = r_ei[39] ? 40'(-r_ei) : r_ei;
    assign w_diff     = 18'(r_err) - 18'(r_last_err);
    assign w_abs_prod = r_prod[pca_pkg::ProdW-1] ? pca_pkg::ProdW'(-r_prod) : r_prod;

    // Operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd)
            pca_pkg::C_MUL_P: begin
                w_ma = {19'd0, r_gain_p};
                w_mb = 21'(r_err);
            end
            pca_pkg::C_MUL_ED: begin
                w_ma = {3'd0, r_dt};
                w_mb = 21'(r_err);
            end
            pca_pkg::C_MUL_B: begin
                w_ma = {20'd0, r_limit};
                w_mb = pca_pkg::MS_SCALE;
            end
            pca_pkg::C_MUL_I: begin
                w_ma = {2'd0, w_abs_ei[32:0]};
                w_mb = {5'd0, r_gain_i};
            end
            pca_pkg::C_MUL_D1: begin
                w_ma = 35'(w_diff);
                w_mb = {5'd0, r_gain_d};
            end
            pca_pkg::C_MUL_D2: begin
                w_ma = r_prod[34:0];
                w_mb = pca_pkg::MS_PER_S;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Divide the I product (below 2^33) by 1000: drop 3 bits, then scale by 1/125
    assign w_recip = {31'd0, r_prod[32:3]} * {30'd0, pca_pkg::RECIP_125};

    // Divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = r_prod[pca_pkg::DivW-1:0];
        w_divisor   = {16'd0, r_gain_i};
        case (i_cmd)
            pca_pkg::C_DIV_B: begin
                w_div_start = 1'b1;
            end
            pca_pkg::C_DIV_D: begin
                w_div_start = 1'b1;
                w_dividend  = w_abs_prod[pca_pkg::DivW-1:0];
                w_divisor   = r_dt;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    pca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_lim   = {12'd0, r_limit, 8'd0};
    assign w_integ = (35'(r_p) < w_lim) && (35'(r_p) > -w_lim);
    assign w_acc   = 50'(r_ei) + r_prod[49:0];
    assign w_bound = {7'd0, w_quo[33:0]};
    assign w_dterm = r_d_neg ? -{2'b00, w_quo} : {2'b00, w_quo};
    assign w_sum   = 46'(r_p) + 46'(r_iterm) + w_dterm;

    always_comb begin
        if (w_sum > 46'(w_lim)) begin
            w_clip = w_lim[23:0];
        end else if (w_sum < -46'(w_lim)) begin
            w_clip = 24'(-w_lim);
        end else begin
            w_clip = w_sum[23:0];
        end
    end

    // Truncate toward zero on the divide by 256
    assign w_adj = w_clip[23] ? w_clip + 24'sd255 : w_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_limit     <= pca_pkg::LIMIT_RESET;
            r_last_err  <= '0;
            r_ei        <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pca_pkg::REG_GAIN_P: r_gain_p <= i_cfg_data;
                    pca_pkg::REG_GAIN_I: r_gain_i <= i_cfg_data;
                    pca_pkg::REG_GAIN_D: r_gain_d <= i_cfg_data;
                    pca_pkg::REG_LIMIT:  r_limit  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_cmd == pca_pkg::C_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                pca_pkg::C_LOAD: begin
                    r_op  <= i_op;
                    r_err <= 17'(i_target) - 17'(i_measured);
                    r_now <= i_time_ms;
                    r_dt  <= i_time_ms - r_last_time;
                end
                pca_pkg::C_CLEAR: begin
                    r_last_err  <= '0;
                    r_ei        <= '0;
                    r_last_time <= r_now;
                    r_res       <= '0;
                end
                pca_pkg::C_ZERO: r_res <= '0;
                pca_pkg::C_MUL_P, pca_pkg::C_MUL_B, pca_pkg::C_MUL_D1,
                pca_pkg::C_MUL_D2: r_prod <= w_prod;
                pca_pkg::C_MUL_ED: begin
                    r_p    <= r_prod[33:0];
                    r_prod <= w_prod;
                end
                pca_pkg::C_INTEG: begin
                    r_iterm <= '0;
                    if (w_integ) begin
                        if (w_acc > pca_pkg::INTEG_MAX) begin
                            r_ei <= pca_pkg::INTEG_MAX[39:0];
                        end else if (w_acc < pca_pkg::INTEG_MIN) begin
                            r_ei <= pca_pkg::INTEG_MIN[39:0];
                        end else begin
                            r_ei <= w_acc[39:0];
                        end
                    end
                end
                pca_pkg::C_CLAMP: begin
                    if (41'(r_ei) > w_bound) begin
                        r_ei <= w_bound[39:0];
                    end else if (41'(r_ei) < -w_bound) begin
                        r_ei <= 40'(-w_bound);
                    end
                end
                pca_pkg::C_MUL_I: begin
                    r_i_neg <= r_ei[39];
                    r_prod  <= w_prod;
                end
                pca_pkg::C_DIV_I: r_iq <= w_recip[60:37];
                pca_pkg::C_GET_I: begin
                    r_iterm <= r_i_neg ? -{1'b0, r_iq} : {1'b0, r_iq};
                end
                pca_pkg::C_DIV_D: r_d_neg <= r_prod[pca_pkg::ProdW-1];
                pca_pkg::C_SUM: begin
                    r_res       <= w_adj[23:8];
                    r_last_err  <= r_err;
                    r_last_time <= r_now;
                end
                pca_pkg::C_PUSH: begin
                    r_out_drive <= r_res;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.op_clear    = r_op;
    assign o_stat.dt_zero     = (r_dt == 32'd0);
    assign o_stat.gain_i_zero = (r_gain_i == 16'd0);
    assign o_stat.div_done    = w_div_done;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of the PID controller with conditional-integration anti-windup
module tb_top;

    localparam bit OP_STEP  = 1'b0;
    localparam bit OP_CLEAR = 1'b1;
    localparam logic [pca_pkg::IdxW-1:0] REG_NONE = 8'd7;
    localparam longint WIND_MAX = 64'sd549755813887;
    localparam longint WIND_MIN = -64'sd549755813888;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_op;
    logic signed [15:0] i_target;
    logic signed [15:0] i_measured;
    logic [31:0]        i_time_ms;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_drive;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [pca_pkg::IdxW-1:0] i_cfg_index;
    logic [15:0]        i_cfg_data;

    pid_controller_anti_windup_unit DUT (.*);

    // Predictor copy of the gains, limit and controller state
    logic [15:0]    kp_q, ki_q, kd_q;
    logic [14:0]    lim_q;
    longint         prev_err;
    longint         err_sum;
    logic [31:0]    prev_ms;

    logic signed [15:0] drive_queue[$];
    int  mismatches = 0;
    bit  timed_out;
    int  send_idle_pct, recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well above the slowest legal run
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the predictor by one request, return the expected drive
    function automatic logic signed [15:0] control_drive(bit op, logic signed [15:0] tgt,
                                                          logic signed [15:0] meas,
                                                          logic [31:0] now);
        longint err, lim, prop, iterm, dterm, bound;
        logic [31:0] dt;
        if (op) begin
            prev_err = 0;
            err_sum  = 0;
            prev_ms  = now;
            return 16'sd0;
        end
        err = longint'(tgt) - longint'(meas);
        dt  = now - prev_ms;
        if (dt == 0) return 16'sd0;
        lim  = longint'(lim_q) * 256;
        prop = longint'(kp_q) * err;
        if (prop > -lim && prop < lim)
            err_sum = clip(err_sum + err * longint'(dt), WIND_MIN, WIND_MAX);
        if (ki_q != 0) begin
            bound   = (longint'(lim_q) * 256000) / longint'(ki_q);
            err_sum = clip(err_sum, -bound, bound);
        end
        iterm = (longint'(ki_q) * err_sum) / 1000;
        dterm = (longint'(kd_q) * (err - prev_err) * 1000) / longint'(dt);
        prev_err = err;
        prev_ms  = now;
        return 16'(clip(prop + iterm + dterm, -lim, lim) / 256);
    endfunction

    // Write one register while the block is idle; valid stays up for a following write
    task automatic write_reg(logic [pca_pkg::IdxW-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pca_pkg::REG_GAIN_P: kp_q  = val;
            pca_pkg::REG_GAIN_I: ki_q  = val;
            pca_pkg::REG_GAIN_D: kd_q  = val;
            pca_pkg::REG_LIMIT:  lim_q = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                             logic [15:0] lim);
        write_reg(pca_pkg::REG_GAIN_P, kp);
        write_reg(pca_pkg::REG_GAIN_I, ki);
        write_reg(pca_pkg::REG_GAIN_D, kd);
        write_reg(pca_pkg::REG_LIMIT, lim);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every expected drive has come, then let the block settle
    task automatic drain;
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (drive_queue.size() != 0 && guard < 500000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 500000) timed_out = 1'b1;
        repeat (200) @(posedge i_clk);
    endtask

    // Send one request; the expectation is queued once it is accepted.
    // A known row queues its typed-in drive, others the predicted one.
    task automatic send_req(bit op, logic signed [15:0] tgt, logic signed [15:0] meas,
                            logic [31:0] now, bit known, logic signed [15:0] fixed);
        logic signed [15:0] pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_target   <= tgt;
        i_measured <= meas;
        i_time_ms  <= now;
        do @(posedge i_clk); while (!o_in_ready);
        pred = control_drive(op, tgt, meas, now);
        drive_queue.push_back(known ? fixed : pred);
    endtask

    // Receiver: randomly stall, compare every accepted drive with the oldest expectation
    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (drive_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive %0d", o_drive);
                end else begin
                    want = drive_queue.pop_front();
                    if (o_drive !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: expected %0d actual %0d", want, o_drive);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    typedef struct {
        bit                 op;
        logic signed [15:0] tgt;
        logic signed [15:0] meas;
        logic [31:0]        now;
        bit                 known;
        logic signed [15:0] drive;
    } t_row;

    t_row dir_rows[$];

    task automatic random_phase(int count);
        logic [31:0] now;
        logic signed [15:0] tgt;
        int mode;
        now = prev_ms;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            if (mode < 8) begin
                send_req(1'b1, 16'($urandom), 16'($urandom), $urandom, 1'b0, 16'sd0);
                now = prev_ms;
            end else if (mode < 14) begin
                send_req(1'b0, 16'($urandom), 16'($urandom), $urandom, 1'b0, 16'sd0);
            end else begin
                // Mostly a tracking loop: small dt, error near the setpoint
                if ($urandom_range(9) != 0) now = now + $urandom_range(1, 50);
                tgt = 16'($urandom_range(0, 4096)) - 16'sd2048;
                send_req(1'b0, tgt, tgt + 16'($signed($urandom_range(0, 1024)) - 512), now,
                         1'b0, 16'sd0);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_op = 1'b0; i_target = '0; i_measured = '0;
        i_time_ms = '0; i_cfg_valid = 1'b0; i_cfg_index = '0;
        i_cfg_data = '0;
        kp_q = 0; ki_q = 0; kd_q = 0; lim_q = pca_pkg::LIMIT_RESET;
        prev_err = 0; err_sum = 0; prev_ms = 0;
        timed_out = 1'b0;
        send_idle_pct = 32; recv_idle_pct = 86;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset gains give zero drive; zero dt; clear; extremes
        dir_rows.push_back('{OP_STEP, 16'sd100, 16'sd0, 32'd0, 1'b1, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd100, 16'sd0, 32'd5, 1'b1, 16'sd0});
        foreach (dir_rows[r])
            send_req(dir_rows[r].op, dir_rows[r].tgt, dir_rows[r].meas, dir_rows[r].now,
                     dir_rows[r].known, dir_rows[r].drive);
        drain();
        write_reg(REG_NONE, 16'hFFFF);   // out of range, dropped
        set_gains(16'h0100, 16'h0080, 16'h0040, 16'h7FFF);
        dir_rows.delete();
        dir_rows.push_back('{OP_CLEAR, 16'sd0, 16'sd0, 32'd1000, 1'b1, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sh7FFF, -16'sh8000, 32'd1000, 1'b1, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sh7FFF, -16'sh8000, 32'd1001, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_STEP, -16'sh8000, 16'sh7FFF, 32'd1002, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd256, 16'sd0, 32'd2002, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd256, 16'sd0, 32'hFFFF_FFFF, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd256, 16'sd0, 32'd3, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd0, 16'sd1, 32'd0, 1'b0, 16'sd0});
        dir_rows.push_back('{OP_CLEAR, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF, 1'b1, 16'sd0});
        dir_rows.push_back('{OP_STEP, 16'sd5, 16'sd0, 32'hFFFF_FFFF, 1'b1, 16'sd0});
        foreach (dir_rows[r])
            send_req(dir_rows[r].op, dir_rows[r].tgt, dir_rows[r].meas, dir_rows[r].now,
                     dir_rows[r].known, dir_rows[r].drive);
        drain();
        // Zero limit: drive always zero
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_req(OP_STEP, 16'sd1000, -16'sd1000, 32'd50, 1'b1, 16'sd0);
        send_req(OP_STEP, -16'sd1000, 16'sd1000, 32'd60, 1'b1, 16'sd0);
        drain();

        // Random phases over several settings; idling is swapped, then switched off
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 86; recv_idle_pct = 32; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            case (ph)
                0: set_gains(16'h0200, 16'h0000, 16'h0010, 16'h2800);
                1: set_gains(16'h0080, 16'h0100, 16'h0008, 16'h7FFF);
                2: set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                3: set_gains(16'h0001, 16'hFFFF, 16'h0000, 16'h0001);
                4: set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                             16'($urandom_range(0, 256)), 16'($urandom_range(0, 32767)));
                default: set_gains(16'hFFFF, 16'h0001, 16'hFFFF, 16'h4000);
            endcase
            random_phase(65);
            drain();    // also the required full pause of the sender
        end

        if (timed_out) $display("simulation failed");
        else if (mismatches == 0 && drive_queue.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

@@ pid_controller_anti_windup_unit.f @@
+incdir+design
design/pca_pkg.sv
design/pca_div.sv
design/pca_ctrl.sv
design/pca_dp.sv
design/pid_controller_anti_windup_unit.sv
test/tb_top.sv
